@@ rtl/gks_pkg.sv @@
// Shared constants, register map and control types of the Geffe keystream unit.
package gks_pkg;

    // LFSR widths: defaults and the largest width supported
    localparam int WIDTH_A_DEF = 27;
    localparam int WIDTH_B_DEF = 23;
    localparam int WIDTH_C_DEF = 25;
    localparam int LFSR_MAX_W  = 30;

    // Stored widths of the configuration registers
    localparam int CFG_W_A = 27;
    localparam int CFG_W_B = 23;
    localparam int CFG_W_C = 25;

    // Reset values of the tap masks and seeds
    localparam logic [CFG_W_A-1:0] TAP_A_RST = CFG_W_A'((1 << 0) | (1 << 13) | (1 << 16) | (1 << 26));
    localparam logic [CFG_W_B-1:0] TAP_B_RST = CFG_W_B'((1 << 0) | (1 << 5) | (1 << 7) | (1 << 22));
    localparam logic [CFG_W_C-1:0] TAP_C_RST = CFG_W_C'((1 << 0) | (1 << 17) | (1 << 19) | (1 << 24));
    localparam logic [CFG_W_A-1:0] SEED_A_RST = CFG_W_A'(1);
    localparam logic [CFG_W_B-1:0] SEED_B_RST = CFG_W_B'(1);
    localparam logic [CFG_W_C-1:0] SEED_C_RST = CFG_W_C'(1);

    // Configuration port geometry and register indexes (byte address = 4 * index)
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_TAP_A  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAP_B  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAP_C  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEED_A = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEED_B = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SEED_C = 3'd5;

    // Action codes carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Stream payload width
    localparam int TDATA_W = 8;

    // Per-beat control handed to the shift-register rows and their cells
    typedef struct packed {
        logic load;
        logic step;
    } gks_ctl_t;

endpackage

@@ rtl/gks_cell.sv @@
// One bit cell of a shift-register row: holds a bit, takes its left neighbor's bit on a step.
module gks_cell #(
    parameter logic RESET_BIT = 1'b0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  gks_pkg::gks_ctl_t ctl,
    input  logic            seed_bit,
    input  logic            shift_in,
    input  logic            tap_bit,
    output logic            bit_q,
    output logic            tap_term
);
    import gks_pkg::*;

    logic bit_reg;
    logic bit_next;

    always_comb begin
        bit_next = bit_reg;
        if (ctl.load) begin
            bit_next = seed_bit;
        end else if (ctl.step) begin
            bit_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= RESET_BIT;
        end else begin
            bit_reg <= bit_next;
        end
    end

    assign bit_q    = bit_reg;
    assign tap_term = bit_reg & tap_bit;

endmodule

@@ rtl/gks_lfsr.sv @@
// Right-shifting Fibonacci LFSR built as a row of bit cells with parity feedback into the top cell.
module gks_lfsr #(
    parameter int WIDTH = gks_pkg::WIDTH_A_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gks_pkg::gks_ctl_t             ctl,
    input  logic [gks_pkg::LFSR_MAX_W-1:0] seed,
    input  logic [gks_pkg::LFSR_MAX_W-1:0] taps,
    output logic [WIDTH-1:0]              state
);
    import gks_pkg::*;

    logic [WIDTH-1:0] bits;
    logic [WIDTH-1:0] terms;
    logic [WIDTH-1:0] shift_in;
    logic             feedback;

    // Parity of the tapped bits, taken before the shift
    assign feedback = ^terms;

    genvar i;
    generate
        for (i = 0; i < WIDTH; i++) begin : g_cell
            if (i == WIDTH - 1) begin : g_top
                assign shift_in[i] = feedback;
            end else begin : g_mid
                assign shift_in[i] = bits[i+1];
            end

            gks_cell #(
                .RESET_BIT ((i == 0) ? 1'b1 : 1'b0)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .seed_bit (seed[i]),
                .shift_in (shift_in[i]),
                .tap_bit  (taps[i]),
                .bit_q    (bits[i]),
                .tap_term (terms[i])
            );
        end
    endgenerate

    assign state = bits;

endmodule

@@ rtl/geffe_keystream_cipher_unit.sv @@
// Top level of the Geffe keystream unit: config registers, three LFSR rows, combiner, output stage.
// A result beat is registered and presented in the cycle after its input beat is accepted.
// Throughput: one beat per cycle unless m_tready stalls; rows shift or reload in the cycle it is taken.
// The single output register lets a new beat in whenever it is empty or being drained.
// Reset (aresetn low, synchronous): tap masks and seeds return to their defaults, every
// LFSR holds 1, and the output stage empties.
module geffe_keystream_cipher_unit #(
    parameter int WIDTH_A = gks_pkg::WIDTH_A_DEF,
    parameter int WIDTH_B = gks_pkg::WIDTH_B_DEF,
    parameter int WIDTH_C = gks_pkg::WIDTH_C_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gks_pkg::TDATA_W-1:0]   s_tdata,   // [0] data_bit, [7:1] zero fill
    input  logic [0:0]                    s_tuser,   // [0] action (0 load, 1 step)
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gks_pkg::TDATA_W-1:0]   m_tdata,   // [0] key_bit, [1] out_bit, [7:2] zero
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gks_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gks_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gks_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import gks_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W_A-1:0] tap_a_reg,  seed_a_reg;
    logic [CFG_W_B-1:0] tap_b_reg,  seed_b_reg;
    logic [CFG_W_C-1:0] tap_c_reg,  seed_c_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_a_reg  <= TAP_A_RST;
            tap_b_reg  <= TAP_B_RST;
            tap_c_reg  <= TAP_C_RST;
            seed_a_reg <= SEED_A_RST;
            seed_b_reg <= SEED_B_RST;
            seed_c_reg <= SEED_C_RST;
        end else if (cfg_wr) begin
            // keep only the stored width; indexes past the map are dropped
            unique case (reg_idx)
                REG_TAP_A:  tap_a_reg  <= pwdata[CFG_W_A-1:0];
                REG_TAP_B:  tap_b_reg  <= pwdata[CFG_W_B-1:0];
                REG_TAP_C:  tap_c_reg  <= pwdata[CFG_W_C-1:0];
                REG_SEED_A: seed_a_reg <= pwdata[CFG_W_A-1:0];
                REG_SEED_B: seed_b_reg <= pwdata[CFG_W_B-1:0];
                REG_SEED_C: seed_c_reg <= pwdata[CFG_W_C-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero for unmapped addresses
    always_comb begin
        unique case (reg_idx)
            REG_TAP_A:  prdata = APB_DATA_W'(tap_a_reg);
            REG_TAP_B:  prdata = APB_DATA_W'(tap_b_reg);
            REG_TAP_C:  prdata = APB_DATA_W'(tap_c_reg);
            REG_SEED_A: prdata = APB_DATA_W'(seed_a_reg);
            REG_SEED_B: prdata = APB_DATA_W'(seed_b_reg);
            REG_SEED_C: prdata = APB_DATA_W'(seed_c_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input handshake and row control
    // ------------------------------------------------------------------
    logic     m_valid_reg, m_valid_next;
    logic     key_reg,     key_next;
    logic     out_reg,     out_next;
    logic     s_accept;
    logic     in_action;
    logic     in_data;
    gks_ctl_t row_ctl;

    // Take a beat whenever the output stage is empty or drains this cycle
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign in_action = s_tuser[0];
    assign in_data   = s_tdata[0];

    assign row_ctl.load = s_accept && (in_action == ACT_LOAD);
    assign row_ctl.step = s_accept && (in_action == ACT_STEP);

    // ------------------------------------------------------------------
    // Three LFSR cell rows: A selects, B and C supply the key bit
    // ------------------------------------------------------------------
    logic [WIDTH_A-1:0] state_a;
    logic [WIDTH_B-1:0] state_b;
    logic [WIDTH_C-1:0] state_c;

    gks_lfsr #(.WIDTH (WIDTH_A)) u_lfsr_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (row_ctl),
        .seed    (LFSR_MAX_W'(seed_a_reg)),
        .taps    (LFSR_MAX_W'(tap_a_reg)),
        .state   (state_a)
    );

    gks_lfsr #(.WIDTH (WIDTH_B)) u_lfsr_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (row_ctl),
        .seed    (LFSR_MAX_W'(seed_b_reg)),
        .taps    (LFSR_MAX_W'(tap_b_reg)),
        .state   (state_b)
    );

    gks_lfsr #(.WIDTH (WIDTH_C)) u_lfsr_c (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (row_ctl),
        .seed    (LFSR_MAX_W'(seed_c_reg)),
        .taps    (LFSR_MAX_W'(tap_c_reg)),
        .state   (state_c)
    );

    // Geffe combiner on the bits the rows present before they shift
    logic key_comb;
    assign key_comb = state_a[0] ? state_b[0] : state_c[0];

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        key_next     = key_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            m_valid_next = 1'b1;
            // a load beat answers with zeros
            key_next     = row_ctl.step & key_comb;
            out_next     = row_ctl.step & (key_comb ^ in_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W-2){1'b0}}, out_reg, key_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A load beat puts the masked seed into the selector row
    a_load_seed_a: assert property (@(posedge aclk) disable iff (!aresetn)
        row_ctl.load |=> state_a == $past(WIDTH_A'(LFSR_MAX_W'(seed_a_reg))))
        else $error("selector row does not hold its seed after a load beat");

    // A load beat answers with an all-zero result
    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        row_ctl.load |=> m_tvalid && m_tdata == '0)
        else $error("load beat did not produce a zero result");

    // A step beat's result pairs the key bit with the data bit it encrypted
    a_step_xor: assert property (@(posedge aclk) disable iff (!aresetn)
        row_ctl.step |=> m_tvalid && (m_tdata[1] == (m_tdata[0] ^ $past(in_data))))
        else $error("out_bit does not equal data_bit xor key_bit");

    // Rows hold still while no beat is taken
    a_rows_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(state_a) && $stable(state_b) && $stable(state_c))
        else $error("LFSR rows moved without an accepted beat");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the Geffe keystream unit: stream driver, result monitor, APB config.
`timescale 1ns / 1ps

module tb;
    import gks_pkg::*;

    localparam int HOLD_CYCLES = 200;  // long receiver hold-off that backs the block up
    localparam int PHASE_BEATS = 346;  // random beats per throttle mix

    // The two register indexes past the last register; writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic action;
        logic data_bit;
    } cipher_beat_t;

    typedef struct packed {
        logic key_bit;
        logic out_bit;
    } keystream_res_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata  = '0;   // [0] data_bit, [7:1] zero fill
    logic [0:0]            s_tuser  = '0;   // [0] action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;         // [0] key_bit, [1] out_bit, [7:2] zero fill
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    geffe_keystream_cipher_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Model of the generator: configuration copy and the three shift registers
    logic [CFG_W_A-1:0] tap_a  = TAP_A_RST;
    logic [CFG_W_B-1:0] tap_b  = TAP_B_RST;
    logic [CFG_W_C-1:0] tap_c  = TAP_C_RST;
    logic [CFG_W_A-1:0] seed_a = SEED_A_RST;
    logic [CFG_W_B-1:0] seed_b = SEED_B_RST;
    logic [CFG_W_C-1:0] seed_c = SEED_C_RST;
    logic [WIDTH_A_DEF-1:0] lfsr_a = SEED_A_RST;
    logic [WIDTH_B_DEF-1:0] lfsr_b = SEED_B_RST;
    logic [WIDTH_C_DEF-1:0] lfsr_c = SEED_C_RST;

    cipher_beat_t   pending_beats[$];   // beats still to be offered
    keystream_res_t expected_bits[$];   // keystream results owed by the block

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_asked      = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int step_beats      = 0;
    int load_beats      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int readback_errors = 0;
    int cfg_writes      = 0;

    // Advance the generator by one beat: reload on a load, else shift all three registers
    function automatic keystream_res_t keystream_next(input logic action, input logic data_bit);
        keystream_res_t res;
        logic sel_bit, b_bit, c_bit;
        res = '0;
        if (action == ACT_LOAD) begin
            lfsr_a = seed_a;
            lfsr_b = seed_b;
            lfsr_c = seed_c;
            return res;
        end
        sel_bit = lfsr_a[0];
        b_bit   = lfsr_b[0];
        c_bit   = lfsr_c[0];
        // feedback is the parity of the tapped bits, taken before the shift
        lfsr_a = {^(lfsr_a & tap_a), lfsr_a[WIDTH_A_DEF-1:1]};
        lfsr_b = {^(lfsr_b & tap_b), lfsr_b[WIDTH_B_DEF-1:1]};
        lfsr_c = {^(lfsr_c & tap_c), lfsr_c[WIDTH_C_DEF-1:1]};
        res.key_bit = sel_bit ? b_bit : c_bit;
        res.out_bit = res.key_bit ^ data_bit;
        return res;
    endfunction

    function automatic logic [APB_DATA_W-1:0] cfg_value(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_TAP_A:  return APB_DATA_W'(tap_a);
            REG_TAP_B:  return APB_DATA_W'(tap_b);
            REG_TAP_C:  return APB_DATA_W'(tap_c);
            REG_SEED_A: return APB_DATA_W'(seed_a);
            REG_SEED_B: return APB_DATA_W'(seed_b);
            REG_SEED_C: return APB_DATA_W'(seed_c);
            default:    return '0;
        endcase
    endfunction

    // Stream driver: predict on every accepted beat, then offer the next one when the slot frees
    always @(posedge aclk) begin
        cipher_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_bits.push_back(keystream_next(s_tuser[0], s_tdata[0]));
                if (s_tuser[0] == ACT_LOAD)
                    load_beats++;
                else
                    step_beats++;
            end
            // hold the beat while the block stalls
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    beat = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(TDATA_W-1){1'b0}}, beat.data_bit};
                    s_tuser  <= beat.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a requested hold-off takes priority over the random stall rate
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each accepted result beat with the oldest expectation
    always @(posedge aclk) begin
        keystream_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bits.size() == 0) begin
                $error("result beat with no expectation: m_tdata=%0h", m_tdata);
                mismatches++;
            end else begin
                want = expected_bits.pop_front();
                results_checked++;
                if (m_tdata[0] !== want.key_bit) begin
                    $error("key_bit: expected %0d, got %0d", want.key_bit, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== want.out_bit) begin
                    $error("out_bit: expected %0d, got %0d", want.out_bit, m_tdata[1]);
                    mismatches++;
                end
            end
        end
    end

    // Setup then access; the register takes the value at the edge that ends the access
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
        // values are cut to the register width; spare addresses change nothing
        case (idx)
            REG_TAP_A:  tap_a  = value[CFG_W_A-1:0];
            REG_TAP_B:  tap_b  = value[CFG_W_B-1:0];
            REG_TAP_C:  tap_c  = value[CFG_W_C-1:0];
            REG_SEED_A: seed_a = value[CFG_W_A-1:0];
            REG_SEED_B: seed_b = value[CFG_W_B-1:0];
            REG_SEED_C: seed_c = value[CFG_W_C-1:0];
            default: ;
        endcase
    endtask

    task automatic check_readback();
        logic [APB_DATA_W-1:0] got;
        for (int i = REG_TAP_A; i <= REG_SEED_C; i++) begin
            @(posedge aclk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {REG_IDX_W'(i), 2'b00};
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got !== cfg_value(REG_IDX_W'(i))) begin
                $error("prdata[%0d]: expected %0h, got %0h", i, cfg_value(REG_IDX_W'(i)), got);
                readback_errors++;
            end
        end
    endtask

    task automatic queue_beat(input logic action, input logic data_bit);
        cipher_beat_t beat;
        beat.action   = action;
        beat.data_bit = data_bit;
        pending_beats.push_back(beat);
    endtask

    // Mostly steps with random data, a few reloads to bring the seeds back in
    task automatic queue_random_beats(input int count);
        for (int i = 0; i < count; i++)
            queue_beat(($urandom_range(0, 99) < 6) ? ACT_LOAD : ACT_STEP, 1'($urandom()));
    endtask

    // Wait until every beat is taken and answered, then let the registered output stage settle
    task automatic drain();
        @(negedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || expected_bits.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic random_config();
        cfg_write(REG_TAP_A,  $urandom());
        cfg_write(REG_TAP_B,  $urandom());
        cfg_write(REG_TAP_C,  $urandom());
        cfg_write(REG_SEED_A, $urandom());
        cfg_write(REG_SEED_B, $urandom());
        cfg_write(REG_SEED_C, $urandom());
        cfg_write(REG_SPARE_HI, $urandom());
        check_readback();
    endtask

    initial begin
        int idle_mix[4][2];
        idle_mix = '{'{0, 0}, '{67, 0}, '{0, 67}, '{32, 32}};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset state: every seed register holds one, default taps
        check_readback();
        queue_beat(ACT_STEP, 1'b0);
        queue_beat(ACT_STEP, 1'b1);
        queue_beat(ACT_STEP, 1'b1);
        queue_beat(ACT_STEP, 1'b1);
        queue_beat(ACT_LOAD, 1'b1);   // load answers zeros whatever the data bit
        queue_beat(ACT_STEP, 1'b0);
        queue_beat(ACT_STEP, 1'b1);
        drain();

        // Over-wide values on every register, writes to the spare addresses dropped
        cfg_write(REG_TAP_A,  '1);
        cfg_write(REG_TAP_B,  '1);
        cfg_write(REG_TAP_C,  '1);
        cfg_write(REG_SEED_A, '1);
        cfg_write(REG_SEED_B, '1);
        cfg_write(REG_SEED_C, '1);
        cfg_write(REG_SPARE_LO, 32'h0);
        cfg_write(REG_SPARE_HI, 32'h0);
        check_readback();
        queue_beat(ACT_LOAD, 1'b0);
        queue_beat(ACT_STEP, 1'b1);
        queue_beat(ACT_STEP, 1'b1);
        queue_beat(ACT_STEP, 1'b0);
        queue_beat(ACT_STEP, 1'b1);
        drain();

        // All-zero seeds: the registers must stay zero, no lockup escape
        cfg_write(REG_SEED_A, 32'h0);
        cfg_write(REG_SEED_B, 32'h0);
        cfg_write(REG_SEED_C, 32'h0);
        queue_beat(ACT_LOAD, 1'b1);
        queue_beat(ACT_STEP, 1'b0);
        queue_beat(ACT_STEP, 1'b1);
        queue_beat(ACT_STEP, 1'b1);
        drain();

        // Zero taps with full seeds: registers shift in zeros
        cfg_write(REG_TAP_A,  32'h0);
        cfg_write(REG_TAP_B,  32'h0);
        cfg_write(REG_TAP_C,  32'h0);
        cfg_write(REG_SEED_A, 32'(2**CFG_W_A - 1));
        cfg_write(REG_SEED_B, 32'(2**CFG_W_B - 1));
        cfg_write(REG_SEED_C, 32'(2**CFG_W_C - 1));
        check_readback();
        queue_beat(ACT_LOAD, 1'b0);
        queue_beat(ACT_STEP, 1'b0);
        queue_beat(ACT_STEP, 1'b1);
        queue_beat(ACT_STEP, 1'b0);
        drain();

        // Random part: one throttle mix per phase, a fresh configuration each time
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 0) begin
                // start from the default taps with random seeds
                cfg_write(REG_TAP_A,  32'(TAP_A_RST));
                cfg_write(REG_TAP_B,  32'(TAP_B_RST));
                cfg_write(REG_TAP_C,  32'(TAP_C_RST));
                cfg_write(REG_SEED_A, $urandom());
                cfg_write(REG_SEED_B, $urandom());
                cfg_write(REG_SEED_C, $urandom());
            end else begin
                random_config();
            end
            @(negedge aclk);
            send_idle_pct  = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            queue_beat(ACT_LOAD, 1'($urandom()));
            queue_random_beats(PHASE_BEATS / 2);
            if (ph == 0) begin
                // back the block up: receiver holds off while the sender keeps offering
                while (pending_beats.size() > PHASE_BEATS / 2 - 40)
                    @(negedge aclk);
                hold_asked++;
            end
            // sender pauses here until every result is back
            drain();
            queue_random_beats(PHASE_BEATS - PHASE_BEATS / 2 - 1);
            drain();
        end

        $display("Ran %0d step and %0d load beats under four throttle mixes, %0d results checked.",
                 step_beats, load_beats, results_checked);
        $display("Made %0d register writes covering extremes, spare addresses and random setups.",
                 cfg_writes);
        if (mismatches == 0 && readback_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
